### hw/rtl/spca_pkg.sv
package spca_pkg;
  localparam int SLOT_W = 4;
  localparam int IDX_W = 6;
  localparam int HANDLE_W = 10;
  localparam int CNT_W = 7;
  localparam int NSLOT_W = 5;
  localparam logic [NSLOT_W-1:0] NONE_SLOT = 5'd16;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam logic [0:0] REG_CHUNKS = 1'b0;
  localparam logic [0:0] REG_LEVEL = 1'b1;

  typedef struct packed {
    logic cmd;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic [HANDLE_W-1:0] alloc_handle;
  } out_item_t;
endpackage

### hw/rtl/spca_link_mem.sv
module spca_link_mem (
  input  logic clk,
  input  logic we,
  input  logic [spca_pkg::HANDLE_W-1:0] waddr,
  input  logic [spca_pkg::IDX_W-1:0] wdata,
  input  logic [spca_pkg::HANDLE_W-1:0] raddr,
  output logic [spca_pkg::IDX_W-1:0] rdata
);
  import spca_pkg::*;
  logic [IDX_W-1:0] mem [0:(1<<HANDLE_W)-1];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/slab_pool_chunk_allocator_unit.sv
// Channel | Ports                           | Handshake
// input   | in_start, in_busy, in_data      | accepted when in_start && !in_busy
// result  | out_strobe, out_data            | one cycle, no stall
// config  | cfg_psel..cfg_prdata, cfg_pready| write in access cycle
// Each transaction reads the chunk link memory (one synchronous read port)
// as it is accepted, then runs a modify/write-back cycle that busy covers.
// The result is registered out of that cycle. Reset is synchronous rst_n.
// Block slot state sits in flip-flops; the receiver cannot stall results.
module slab_pool_chunk_allocator_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  output logic in_busy,
  input  spca_pkg::in_item_t in_data,
  output logic out_strobe,
  output spca_pkg::out_item_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import spca_pkg::*;
  localparam int NB = 16;

  logic [6:0] cpb_r;
  logic [5:0] lvl_r;
  logic [IDX_W-1:0] top_r [0:NB-1];
  logic [CNT_W-1:0] frd_r [0:NB-1];
  logic [CNT_W-1:0] unt_r [0:NB-1];
  logic [CNT_W-1:0] used_r [0:NB-1];
  logic [NSLOT_W-1:0] nxt_r [0:NB-1];
  logic [NSLOT_W-1:0] prv_r [0:NB-1];
  logic [NB-1:0] busy_r;
  logic [NSLOT_W-1:0] head_r, tail_r;
  logic [NSLOT_W-1:0] live_r;
  logic ph_r;
  in_item_t req_r;
  logic [SLOT_W-1:0] as_r;
  logic claim_r, fail_r;
  logic [CNT_W-1:0] eff_r;

  logic [CNT_W-1:0] eff;
  always_comb begin
    if (cpb_r == 7'd0) eff = 7'd1;
    else if (cpb_r > 7'd64) eff = 7'd64;
    else eff = cpb_r;
  end

  function automatic logic exh(input logic [CNT_W-1:0] u, f, t, e);
    return (u >= e) || (f == '0 && t == '0);
  endfunction

  // phase 0 choice: target slot for alloc
  logic need_claim;
  logic [SLOT_W-1:0] low_free;
  logic any_free;
  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = NB-1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        low_free = SLOT_W'(i);
        any_free = 1'b1;
      end
    end
    need_claim = head_r[NSLOT_W-1] ||
                 exh(used_r[head_r[SLOT_W-1:0]], frd_r[head_r[SLOT_W-1:0]],
                     unt_r[head_r[SLOT_W-1:0]], eff);
  end

  logic acc;
  assign acc = in_start && !in_busy;
  assign in_busy = ph_r;

  logic [SLOT_W-1:0] sel_slot;
  assign sel_slot = need_claim ? low_free : head_r[SLOT_W-1:0];

  logic lwe;
  logic [HANDLE_W-1:0] lwa, lra;
  logic [IDX_W-1:0] lwd, lrd;
  assign lra = {sel_slot, top_r[sel_slot]};
  spca_link_mem u_link (.clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd),
                        .raddr(lra), .rdata(lrd));

  wire [SLOT_W-1:0] fs = req_r.handle[HANDLE_W-1:IDX_W];
  wire [IDX_W-1:0] fi = req_r.handle[IDX_W-1:0];
  assign lwe = ph_r && req_r.cmd == CMD_FREE && busy_r[fs] && used_r[fs] != '0;
  assign lwa = req_r.handle;
  assign lwd = top_r[fs];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= 7'd64;
      lvl_r <= 6'd47;
      busy_r <= '0;
      head_r <= NONE_SLOT;
      tail_r <= NONE_SLOT;
      live_r <= '0;
      ph_r <= 1'b0;
      out_strobe <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        frd_r[i] <= '0;
        unt_r[i] <= '0;
        used_r[i] <= '0;
      end
    end else begin
      out_strobe <= ph_r;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == REG_CHUNKS) cpb_r <= cfg_pwdata[6:0];
        else lvl_r <= cfg_pwdata[5:0];
      end
      if (acc) begin
        ph_r <= 1'b1;
        req_r <= in_data;
        as_r <= sel_slot;
        claim_r <= need_claim;
        fail_r <= need_claim && !any_free;
        eff_r <= eff;
      end
      if (ph_r) begin : exec
        logic [SLOT_W-1:0] s;
        logic [NSLOT_W-1:0] hd, tl, lv, nh, nx, pv, s5;
        logic [CNT_W-1:0] f, t, u;
        logic [IDX_W-1:0] idx;
        logic mv;
        out_item_t o;
        hd = head_r; tl = tail_r; lv = live_r;
        o = '0;
        ph_r <= 1'b0;
        if (req_r.cmd == CMD_ALLOC) begin
          s = as_r;
          s5 = {1'b0, s};
          if (fail_r) begin
            o.status = STATUS_FULL;
          end else begin
            f = frd_r[s]; t = unt_r[s]; u = used_r[s];
            if (claim_r) begin
              busy_r[s] <= 1'b1;
              f = '0; t = eff_r; u = '0;
              if (lv == '0) tl = s5;
              lv = lv + 1'b1;
              pv = NONE_SLOT;
              nx = hd;
              nh = hd;
              hd = s5;
            end else begin
              pv = prv_r[s];
              nx = nxt_r[s];
              nh = nx;
            end
            if (f != '0) begin
              idx = top_r[s][IDX_W-1:0];
              top_r[s] <= lrd;
              f = f - 1'b1;
            end else begin
              t = t - 1'b1;
              idx = t[IDX_W-1:0];
            end
            u = u + 1'b1;
            frd_r[s] <= f; unt_r[s] <= t; used_r[s] <= u;
            o.alloc_handle = {s, idx};
            mv = exh(u, f, t, eff) && lv > 5'd1;
            // move the exhausted head to the tail
            if (mv) begin
              pv = tl;
              if (!tl[NSLOT_W-1]) nxt_r[tl[SLOT_W-1:0]] <= s5;
              tl = s5;
              hd = nh;
              nx = NONE_SLOT;
              if (!nh[NSLOT_W-1]) prv_r[nh[SLOT_W-1:0]] <= NONE_SLOT;
            end else if (claim_r && live_r != '0 && !nh[NSLOT_W-1]) begin
              prv_r[nh[SLOT_W-1:0]] <= s5;
            end
            prv_r[s] <= pv;
            nxt_r[s] <= nx;
          end
        end else if (lwe) begin
          s = fs;
          s5 = {1'b0, s};
          u = used_r[s] - 1'b1;
          top_r[s] <= fi;
          frd_r[s] <= frd_r[s] + 1'b1;
          used_r[s] <= u;
          if (s5 != hd && (u == '0 || u == {1'b0, lvl_r})) begin
            nx = nxt_r[s]; pv = prv_r[s];
            if (s5 == tl) tl = pv;
            else if (!nx[NSLOT_W-1]) prv_r[nx[SLOT_W-1:0]] <= pv;
            if (!pv[NSLOT_W-1]) nxt_r[pv[SLOT_W-1:0]] <= nx;
            if (u == '0) begin
              busy_r[s] <= 1'b0;
              if (lv != '0) lv = lv - 1'b1;
            end else begin
              prv_r[s] <= NONE_SLOT;
              if (!hd[NSLOT_W-1]) prv_r[hd[SLOT_W-1:0]] <= s5;
              nxt_r[s] <= hd;
              hd = s5;
            end
          end
        end
        out_data <= o;
        head_r <= hd; tail_r <= tl; live_r <= lv;
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CHUNKS) ? {25'd0, cpb_r} : {26'd0, lvl_r};

`ifndef SYNTH
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_busy)) else $error("strobe without work");
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_busy |=> !in_busy) else $error("busy too long");
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= 5'd16) else $error("live count overflow");
`endif
endmodule

### tb/sv/slab_pool_chunk_allocator_unit_tb.sv
module slab_pool_chunk_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spca_pkg::*;

  localparam int NBLK = 16;
  localparam int NCHK = 64;
  localparam int STALL_LIMIT = 5000;

  class chunk_pool_scoreboard;
    logic [6:0] chunks_reg;
    logic [5:0] level_reg;
    int unsigned link_mem [NBLK*NCHK];
    int unsigned top_idx [NBLK];
    int unsigned freed [NBLK];
    int unsigned fresh [NBLK];
    int unsigned used [NBLK];
    int unsigned nxt [NBLK];
    int unsigned prv [NBLK];
    bit busy_slot [NBLK];
    int unsigned head, tail, live;
    out_item_t expected_q[$];
    logic [HANDLE_W-1:0] held_handles[$];
    int errors;

    function new();
      chunks_reg = 7'd64;
      level_reg = 6'd47;
      head = NBLK;
      tail = NBLK;
      live = 0;
      errors = 0;
      for (int i = 0; i < NBLK; i++) begin
        freed[i] = 0; fresh[i] = 0; used[i] = 0; busy_slot[i] = 0;
        top_idx[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
    endfunction

    function int unsigned chunk_limit();
      if (chunks_reg < 1) return 1;
      if (chunks_reg > NCHK) return NCHK;
      return chunks_reg;
    endfunction

    function bit is_full(int unsigned s);
      return used[s] >= chunk_limit() || (freed[s] == 0 && fresh[s] == 0);
    endfunction

    function void set_nxt(int unsigned s, int unsigned v);
      if (s < NBLK) nxt[s] = v;
    endfunction

    function void set_prv(int unsigned s, int unsigned v);
      if (s < NBLK) prv[s] = v;
    endfunction

    function out_item_t grab_chunk();
      out_item_t r;
      int unsigned s, n, idx, nh;
      r = '0;
      s = head;
      if (s >= NBLK || is_full(s)) begin
        n = NBLK;
        for (int i = NBLK - 1; i >= 0; i--)
          if (!busy_slot[i]) n = i;
        if (n >= NBLK) begin
          r.status = STATUS_FULL;
          return r;
        end
        busy_slot[n] = 1;
        freed[n] = 0;
        fresh[n] = chunk_limit();
        used[n] = 0;
        if (live == 0) tail = n;
        else set_prv(head, n);
        live++;
        prv[n] = NBLK;
        nxt[n] = head;
        head = n;
        s = n;
      end
      if (freed[s] > 0) begin
        idx = top_idx[s] % NCHK;
        top_idx[s] = link_mem[s*NCHK + idx];
        freed[s]--;
      end else begin
        fresh[s]--;
        idx = fresh[s];
      end
      used[s]++;
      r.status = STATUS_OK;
      r.alloc_handle = HANDLE_W'(s*NCHK + idx);
      held_handles.push_back(r.alloc_handle);
      if (is_full(s) && live > 1) begin
        nh = (s < NBLK) ? nxt[s] : NBLK;
        set_prv(s, tail);
        set_nxt(tail, s);
        tail = s;
        head = nh;
        set_nxt(s, NBLK);
        set_prv(nh, NBLK);
      end
      return r;
    endfunction

    function void return_chunk(logic [HANDLE_W-1:0] h);
      int unsigned s, idx, nx, pv;
      s = h / NCHK;
      idx = h % NCHK;
      if (s >= NBLK || !busy_slot[s] || used[s] == 0) return;
      link_mem[s*NCHK + idx] = top_idx[s];
      top_idx[s] = idx;
      freed[s]++;
      used[s]--;
      if (s == head || (used[s] != 0 && used[s] != level_reg)) return;
      nx = nxt[s];
      pv = prv[s];
      if (s == tail) tail = pv;
      else set_prv(nx, pv);
      set_nxt(pv, nx);
      if (used[s] == 0) begin
        busy_slot[s] = 0;
        if (live > 0) live--;
      end else begin
        prv[s] = NBLK;
        set_prv(head, s);
        nxt[s] = head;
        head = s;
      end
    endfunction

    function void note_request(in_item_t it);
      if (it.cmd == CMD_ALLOC) begin
        expected_q.push_back(grab_chunk());
      end else begin
        return_chunk(it.handle);
        expected_q.push_back('0);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result status=%0d handle=%0d", got.status, got.alloc_handle);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.alloc_handle !== exp_r.alloc_handle) begin
        $error("alloc_handle: expected %0d, got %0d", exp_r.alloc_handle, got.alloc_handle);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_start, in_busy;
  in_item_t in_data;
  logic out_strobe;
  out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  chunk_pool_scoreboard sb = new();
  int stall_cycles;
  int burst_left;

  slab_pool_chunk_allocator_unit dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_start && !in_busy) sb.note_request(in_data);
      if (out_strobe) sb.check_result(out_data);
      if ((in_start && !in_busy) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_start <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      if (!in_busy) break;
    end
    @(posedge clk);
    // pace the sender in bursts separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic alloc_req();
    in_item_t it;
    it.cmd = CMD_ALLOC;
    it.handle = HANDLE_W'($urandom);
    send_item(it);
  endtask

  task automatic free_req(logic [HANDLE_W-1:0] h);
    in_item_t it;
    it.cmd = CMD_FREE;
    it.handle = h;
    send_item(it);
  endtask

  // release a chunk still held, or a random handle as noise
  task automatic free_some();
    int k;
    logic [HANDLE_W-1:0] h;
    if (sb.held_handles.size() > 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, sb.held_handles.size() - 1);
      h = sb.held_handles[k];
      sb.held_handles.delete(k);
    end else begin
      h = HANDLE_W'($urandom);
    end
    free_req(h);
  endtask

  task automatic drain();
    in_start <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_CHUNKS) sb.chunks_reg = val[6:0];
    else sb.level_reg = val[5:0];
  endtask

  task automatic random_phase(int n, int alloc_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < alloc_pct) alloc_req();
      else free_some();
    end
  endtask

  initial begin
    rst_n = 0;
    in_start = 0;
    in_data = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    stall_cycles = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one chunk per block: fill every slot, overflow, then empty
    write_reg(REG_CHUNKS, 32'd1);
    write_reg(REG_LEVEL, 32'd0);
    repeat (17) alloc_req();
    free_req(10'd1023);
    free_req(10'd0);
    free_req(10'd0);
    while (sb.held_handles.size() > 0) free_some();
    drain();

    // zero acts as one, wide value clamps to the maximum
    write_reg(REG_CHUNKS, 32'd0);
    repeat (3) alloc_req();
    drain();
    write_reg(REG_CHUNKS, 32'd127);
    write_reg(REG_LEVEL, 32'd63);
    random_phase(170, 85);
    drain();

    write_reg(REG_CHUNKS, 32'd64);
    write_reg(REG_LEVEL, 32'd47);
    random_phase(170, 60);
    drain();

    write_reg(REG_CHUNKS, 32'd4);
    write_reg(REG_LEVEL, 32'd2);
    random_phase(170, 55);
    drain();

    write_reg(REG_CHUNKS, 32'd2);
    write_reg(REG_LEVEL, 32'd1);
    random_phase(170, 70);
    drain();

    write_reg(REG_CHUNKS, 32'd8);
    write_reg(REG_LEVEL, 32'd0);
    random_phase(170, 50);
    drain();

    write_reg(REG_CHUNKS, 32'($urandom_range(1, 64)));
    write_reg(REG_LEVEL, 32'($urandom_range(0, 63)));
    random_phase(170, 50);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
